// File: src/lifo_block_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// lifo block allocator assertion macros
// shared wrappers for the concurrent checks of the unit
// ---------------------------------------------------------------------------
`ifndef LIFO_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define LIFO_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, held off while in reset
`define LBA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define LBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lba_pkg.sv
// ---------------------------------------------------------------------------
// lba_pkg
// shared constants, codes and beat types of the lifo block allocator
// ---------------------------------------------------------------------------
`default_nettype none

package lba_pkg;

  // pool geometry
  localparam int NUM_BLOCKS = 1024;
  localparam int ID_W       = 10;   // granted id width
  localparam int CNT_W      = 11;   // free count width, holds NUM_BLOCKS
  localparam int BID_W      = 12;   // request id width
  localparam int BID_XW     = BID_W + 1;

  // request codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } lba_op_t;

  // result codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_INVALID = 2'd2,
    ST_DOUBLE  = 2'd3
  } lba_status_t;

  // request beat
  typedef struct packed {
    lba_op_t           op;
    logic [BID_W-1:0]  block_id;
  } lba_in_beat_t;

  // result beat
  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    lba_status_t       status;
    logic [CNT_W-1:0]  free_count;
  } lba_out_beat_t;

  // free stack control
  typedef struct packed {
    logic             rd;
    logic             pop;
    logic             push;
    logic [ID_W-1:0]  push_id;
  } lba_stk_cmd_t;

  // allocated mark write
  typedef struct packed {
    logic             en;
    logic [ID_W-1:0]  addr;
    logic             val;
  } lba_mark_wr_t;

endpackage

`default_nettype wire

// File: src/lba_ram.sv
// ---------------------------------------------------------------------------
// lba_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module lba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/lba_stack.sv
// ---------------------------------------------------------------------------
// lba_stack
// free id stack: ram, depth pointer and low-water mark for the reset image
// ---------------------------------------------------------------------------
`default_nettype none

module lba_stack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lba_pkg::lba_stk_cmd_t       cmd,
  output logic [lba_pkg::CNT_W-1:0]   depth,
  output logic [lba_pkg::ID_W-1:0]    top_id
);

  import lba_pkg::*;

  logic [CNT_W-1:0] depth_r;
  logic [CNT_W-1:0] depth_nxt;
  logic [CNT_W-1:0] low_r;
  logic [CNT_W-1:0] low_nxt;
  logic [CNT_W-1:0] depth_m1;
  logic [CNT_W-1:0] seed_full;
  logic [ID_W-1:0]  seed_r;
  logic             use_ram_r;
  logic [ID_W-1:0]  ram_q;

  assign depth_m1  = depth_r - CNT_W'(1);
  // reset image of entry depth-1 is NUM_BLOCKS-depth
  assign seed_full = CNT_W'(NUM_BLOCKS) - depth_r;

  // pointer and low-water mark update
  always_comb begin
    depth_nxt = depth_r;
    low_nxt   = low_r;
    if (cmd.pop) begin
      depth_nxt = depth_m1;
      if (depth_m1 < low_r) begin
        low_nxt = depth_m1;
      end
    end else if (cmd.push) begin
      depth_nxt = depth_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= CNT_W'(NUM_BLOCKS);
      low_r   <= CNT_W'(NUM_BLOCKS);
    end else begin
      depth_r <= depth_nxt;
      low_r   <= low_nxt;
    end
  end

  // entries below the low-water mark were never written since reset
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      seed_r    <= seed_full[ID_W-1:0];
      use_ram_r <= (depth_r > low_r);
    end
  end

  lba_ram #(
    .WIDTH (ID_W),
    .DEPTH (NUM_BLOCKS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth_r[ID_W-1:0]),
    .wdata (cmd.push_id),
    .re    (cmd.rd),
    .raddr (depth_m1[ID_W-1:0]),
    .rdata (ram_q)
  );

  assign depth  = depth_r;
  assign top_id = use_ram_r ? ram_q : seed_r;

endmodule

`default_nettype wire

// File: src/lba_marks.sv
// ---------------------------------------------------------------------------
// lba_marks
// allocated mark bitmap in ram, swept to zero after reset
// ---------------------------------------------------------------------------
`default_nettype none

module lba_marks (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [lba_pkg::ID_W-1:0]  rd_addr,
  input  lba_pkg::lba_mark_wr_t     wr,
  output logic                      mark,
  output logic                      clearing
);

  import lba_pkg::*;

  logic             clr_act_r;
  logic [ID_W-1:0]  clr_idx_r;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      clr_idx_r <= clr_idx_r + ID_W'(1);
      if (clr_idx_r == ID_W'(NUM_BLOCKS - 1)) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  lba_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_mark_ram (
    .clk   (clk),
    .we    (clr_act_r | wr.en),
    .waddr (clr_act_r ? clr_idx_r : wr.addr),
    .wdata (clr_act_r ? 1'b0 : wr.val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (mark)
  );

  assign clearing = clr_act_r;

endmodule

`default_nettype wire

// File: src/lifo_block_allocator_unit.sv
// ---------------------------------------------------------------------------
// lifo_block_allocator_unit
// free-list stack allocator for a pool of fixed-size blocks
// ---------------------------------------------------------------------------
//  channel   ports                     handshake
//  request   start, busy, in_beat      taken when start & !busy
//  result    out_valid, out_beat       one-cycle strobe, never stalled
//
//  an accepted request reads the stack top and the mark of its id from
//  the rams; the next cycle decides and writes back, and the result beat
//  shows in the cycle after that. busy stays high while a request is
//  decided, so no new request is taken before it is written back.
//  after reset busy stays high while the mark bitmap is swept to zero.
//  a new request may be taken in the cycle its predecessor's result shows.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lifo_block_allocator_unit_defines.svh"

module lifo_block_allocator_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  lba_pkg::lba_in_beat_t   in_beat,
  output logic                    out_valid,
  output lba_pkg::lba_out_beat_t  out_beat
);

  import lba_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state_r;
  lba_op_t           op_r;
  logic [BID_W-1:0]  id_r;
  logic              out_valid_r;
  lba_out_beat_t     out_beat_r;

  logic              accept;
  logic              clearing;
  logic              mark_q;
  logic [CNT_W-1:0]  depth;
  logic [ID_W-1:0]   top_id;
  lba_stk_cmd_t      stk_cmd;
  lba_mark_wr_t      mark_wr;
  logic              id_bad;
  lba_status_t       status;
  logic [ID_W-1:0]   granted;
  logic [CNT_W-1:0]  cnt;

  assign accept = start && (state_r == S_IDLE);
  assign id_bad = ({1'b0, id_r} >= BID_XW'(NUM_BLOCKS));

  // decide and write back in the exec cycle
  always_comb begin
    stk_cmd         = '0;
    stk_cmd.rd      = accept;
    stk_cmd.push_id = id_r[ID_W-1:0];
    mark_wr         = '0;
    status          = ST_OK;
    granted         = '0;
    cnt             = depth;
    if (state_r == S_EXEC) begin
      if (op_r == OP_ALLOC) begin
        if (depth == '0) begin
          status = ST_OOM;
        end else begin
          stk_cmd.pop  = 1'b1;
          mark_wr.en   = 1'b1;
          mark_wr.addr = top_id;
          mark_wr.val  = 1'b1;
          granted      = top_id;
          cnt          = depth - CNT_W'(1);
        end
      end else begin
        priority if (id_bad) begin
          status = ST_INVALID;
        end else if (!mark_q || (depth == CNT_W'(NUM_BLOCKS))) begin
          status = ST_DOUBLE;
        end else begin
          stk_cmd.push = 1'b1;
          mark_wr.en   = 1'b1;
          mark_wr.addr = id_r[ID_W-1:0];
          mark_wr.val  = 1'b0;
          cnt          = depth + CNT_W'(1);
        end
      end
    end
  end

  // sequencer and result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EXEC);
      if (state_r == S_EXEC) begin
        out_beat_r.granted_id <= granted;
        out_beat_r.status     <= status;
        out_beat_r.free_count <= cnt;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (!clearing) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
            op_r    <= in_beat.op;
            id_r    <= in_beat.block_id;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  lba_stack u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (stk_cmd),
    .depth  (depth),
    .top_id (top_id)
  );

  lba_marks u_marks (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_beat.block_id[ID_W-1:0]),
    .wr       (mark_wr),
    .mark     (mark_q),
    .clearing (clearing)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // checks
  `LBA_ASSERT_IMPL(a_strobe_from_exec, clk, rst_n, out_valid_r, $past(state_r == S_EXEC), "result beat without exec cycle")
  `LBA_ASSERT_IMPL(a_clear_holds_off, clk, rst_n, clearing, state_r == S_CLEAR, "request path active during mark sweep")
  `LBA_ASSERT_IMPL(a_count_in_range, clk, rst_n, out_valid_r, out_beat_r.free_count <= CNT_W'(NUM_BLOCKS), "free count above pool size")
  `LBA_ASSERT_NEXT(a_push_grows, clk, rst_n, (state_r == S_EXEC) && stk_cmd.push, depth == $past(depth) + CNT_W'(1), "push did not grow the stack")
  `LBA_ASSERT_IMPL(a_error_keeps_depth, clk, rst_n, out_valid_r && (out_beat_r.status != ST_OK), depth == $past(depth), "failed request moved the stack")

endmodule

`default_nettype wire
